@@ rtl/core/hfq_pkg.sv @@
// Shared types and constants for the heightfield height query block.
// No dependencies; imported by every module in rtl/core but hfq_div.
package hfq_pkg;

  localparam int HGT_W = 32;   // signed Q16.16 height / coordinate
  localparam int CSW   = 31;   // cell size register width
  localparam int IDX_W = 7;    // load row / column index width
  localparam int MAG_W = 33;   // magnitude of a height difference
  localparam int CFG_IW = 1;   // config register index width

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_CELL_X = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_CELL_Z = 1'b1;

  localparam logic [CSW-1:0] CELL_RESET = 31'd65536;

  localparam logic [HGT_W-1:0] HGT_MAX = 32'h7fff_ffff;
  localparam logic [HGT_W-1:0] HGT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                    cmd;
    logic [IDX_W-1:0]        load_row;
    logic [IDX_W-1:0]        load_col;
    logic signed [HGT_W-1:0] load_height;
    logic signed [HGT_W-1:0] pos_x;
    logic signed [HGT_W-1:0] pos_y;
    logic signed [HGT_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] height_out;
    logic                    inside_res;
  } out_item_t;

endpackage

@@ rtl/core/heightfield_height_query.sv @@
// Top level of the heightfield height query: grid height store plus query pipeline.
// Depends on hfq_pkg, hfq_div and hfq_store.
//
//  channel | ports                          | transfer
//  --------+--------------------------------+--------------------------------------
//  input   | start, busy, in_data           | edge with start high and busy low
//  result  | out_valid, out_data            | edge ending the one-cycle strobe
//  config  | cfg_we, cfg_idx, cfg_wdata     | edge with cfg_we high
//
// One item enters per clock. Most of the depth from a transfer edge to its result
// strobe comes from the bit-per-stage divider pairs (cell location, then interpolation).
// Loads write the store at the same stage where queries read it, so program order
// holds with no bubbles. busy stays low: nothing stalls and the receiver cannot.
// rst_n (synchronous) clears valid bits and sets the cell size registers to CELL_RESET;
// the store content is undefined until loaded.
module heightfield_height_query #(
  parameter int GRID_X = 64,
  parameter int GRID_Z = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  hfq_pkg::in_item_t          in_data,
  output logic                       out_valid,
  output hfq_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [hfq_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [hfq_pkg::CSW-1:0]    cfg_wdata
);
  import hfq_pkg::*;

  localparam int HALF_X  = GRID_X / 2;
  localparam int HALF_Z  = GRID_Z / 2;
  localparam int QXW     = $clog2(GRID_X);
  localparam int QZW     = $clog2(GRID_Z);
  localparam int QL      = (QXW > QZW) ? QXW : QZW;   // cell index bits
  localparam int LNW     = CSW + QL;                  // locate numerator width
  localparam int UW      = LNW + 2;                   // signed offset width
  localparam int STRIDE  = GRID_X + 1;
  localparam int DEPTH   = STRIDE * (GRID_Z + 1);
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = 2 * CSW;                   // triangle test products
  localparam int SNW     = CSW + MAG_W;               // interpolation numerator
  localparam int LATENCY = QL + MAG_W + 9;

  typedef struct packed {
    logic                    qry;
    logic                    ins;
    logic                    uz;
    logic                    wz;
    logic                    neg_x;
    logic                    neg_z;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic [HGT_W-1:0]        hgt;   // load height, later h00
    logic [HGT_W-1:0]        py;
  } side_t;

  // ---------------- configuration ----------------
  logic [CSW-1:0] csx_r, csz_r;
  logic [CSW-1:0] dx, dz;
  logic signed [UW-1:0] dxoff_r, dzoff_r, lx_r, lz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csx_r <= CELL_RESET;
      csz_r <= CELL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CELL_X: csx_r <= cfg_wdata;
        CFG_CELL_Z: csz_r <= cfg_wdata;
      endcase
    end
  end

  // zero spacing acts as one LSB
  assign dx = (csx_r == '0) ? CSW'(1) : csx_r;
  assign dz = (csz_r == '0) ? CSW'(1) : csz_r;

  // grid origin offsets and extents, refreshed every cycle
  always_ff @(posedge clk) begin
    dxoff_r <= UW'(dx) * UW'(HALF_X);
    dzoff_r <= UW'(dz) * UW'(HALF_Z);
    lx_r    <= UW'(dx) * UW'(GRID_X);
    lz_r    <= UW'(dz) * UW'(GRID_Z);
  end

  // ---------------- S1: input register ----------------
  logic     accept;
  logic     vld1_r;
  in_item_t in1_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= accept;
    if (accept) in1_r <= in_data;
  end

  // ---------------- S2: offsets from the top-left vertex ----------------
  logic                 vld2_r;
  side_t                sd2_r, sd2_nxt;
  logic signed [UW-1:0] u2_r, w2_r;

  always_comb begin
    sd2_nxt     = '0;
    sd2_nxt.qry = (in1_r.cmd == CMD_QUERY);
    sd2_nxt.row = in1_r.load_row;
    sd2_nxt.col = in1_r.load_col;
    sd2_nxt.hgt = in1_r.load_height;
    sd2_nxt.py  = in1_r.pos_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else        vld2_r <= vld1_r;
    sd2_r <= sd2_nxt;
    u2_r  <= {{(UW-HGT_W){in1_r.pos_x[HGT_W-1]}}, in1_r.pos_x} + dxoff_r;
    w2_r  <= dzoff_r - {{(UW-HGT_W){in1_r.pos_z[HGT_W-1]}}, in1_r.pos_z};
  end

  // ---------------- S3: bounds check, divider operands ----------------
  logic                 vld3_r;
  side_t                sd3_r, sd3_nxt;
  logic [LNW-1:0]       nx3_r, nz3_r;
  logic signed [UW-1:0] um1, wm1;
  logic                 in_grid;

  assign um1     = u2_r - UW'(1);
  assign wm1     = w2_r - UW'(1);
  assign in_grid = !u2_r[UW-1] && !w2_r[UW-1] && (u2_r <= lx_r) && (w2_r <= lz_r);

  always_comb begin
    sd3_nxt     = sd2_r;
    sd3_nxt.ins = sd2_r.qry & in_grid;
    sd3_nxt.uz  = (u2_r == '0);
    sd3_nxt.wz  = (w2_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld3_r <= 1'b0;
    else        vld3_r <= vld2_r;
    sd3_r <= sd3_nxt;
    // out-of-grid items divide zero so the reads stay in range
    nx3_r <= (sd3_nxt.ins && !sd3_nxt.uz) ? um1[LNW-1:0] : '0;
    nz3_r <= (sd3_nxt.ins && !sd3_nxt.wz) ? wm1[LNW-1:0] : '0;
  end

  // ---------------- cell location: (u-1)/dx, (w-1)/dz ----------------
  logic [QL-1:0]  cq, cr;
  logic [CSW-1:0] remx, remz;

  hfq_div #(.DENW(CSW), .QW(QL)) u_div_col (
    .clk(clk), .num(nx3_r), .den(dx), .quo(cq), .rem(remx)
  );
  hfq_div #(.DENW(CSW), .QW(QL)) u_div_row (
    .clk(clk), .num(nz3_r), .den(dz), .quo(cr), .rem(remz)
  );

  logic [QL-1:0] lvld_r;
  side_t         lsd_r [QL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvld_r <= '0;
    end else begin
      lvld_r[0] <= vld3_r;
      for (int k = 1; k < QL; k++) lvld_r[k] <= lvld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    lsd_r[0] <= sd3_r;
    for (int k = 1; k < QL; k++) lsd_r[k] <= lsd_r[k-1];
  end

  // ---------------- SA: addresses, local offsets, load write ----------------
  side_t          sdl;
  logic           vldA_r;
  side_t          sdA_r;
  logic [AW-1:0]  base, a00_r, a01_r, a10_r, a11_r, waddr_r;
  logic [CSW-1:0] ulA_r, wlA_r;
  logic           we_r;
  logic           load_ok;

  assign sdl     = lsd_r[QL-1];
  assign base    = AW'(cr) * AW'(STRIDE) + AW'(cq);
  assign load_ok = lvld_r[QL-1] && !sdl.qry &&
                   (int'(sdl.row) <= GRID_Z) && (int'(sdl.col) <= GRID_X);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldA_r <= 1'b0;
      we_r   <= 1'b0;
    end else begin
      vldA_r <= lvld_r[QL-1];
      we_r   <= load_ok;
    end
    sdA_r   <= sdl;
    a00_r   <= base;
    a01_r   <= base + AW'(1);
    a10_r   <= base + AW'(STRIDE);
    a11_r   <= base + AW'(STRIDE + 1);
    waddr_r <= AW'(sdl.row) * AW'(STRIDE) + AW'(sdl.col);
    ulA_r   <= sdl.uz ? '0 : remx + CSW'(1);
    wlA_r   <= sdl.wz ? '0 : remz + CSW'(1);
  end

  // two copies: one holds h00/h11, the other h10/h01
  logic [HGT_W-1:0] h00, h11, h10, h01;

  hfq_store #(.DEPTH(DEPTH), .AW(AW)) u_store_diag (
    .clk(clk), .wr_en(we_r), .wr_addr(waddr_r), .wr_data(sdA_r.hgt),
    .rd_addr_a(a00_r), .rd_addr_b(a11_r), .rd_data_a(h00), .rd_data_b(h11)
  );
  hfq_store #(.DEPTH(DEPTH), .AW(AW)) u_store_anti (
    .clk(clk), .wr_en(we_r), .wr_addr(waddr_r), .wr_data(sdA_r.hgt),
    .rd_addr_a(a10_r), .rd_addr_b(a01_r), .rd_data_a(h10), .rd_data_b(h01)
  );

  // ---------------- SM: heights read, triangle test products ----------------
  logic           vldM_r;
  side_t          sdM_r;
  logic [PW-1:0]  pzu_r, pxw_r;
  logic [CSW-1:0] ulM_r, wlM_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vldM_r <= 1'b0;
    else        vldM_r <= vldA_r;
    sdM_r <= sdA_r;
    pzu_r <= PW'(dz) * PW'(ulA_r);
    pxw_r <= PW'(dx) * PW'(wlA_r);
    ulM_r <= ulA_r;
    wlM_r <= wlA_r;
  end

  // ---------------- SD: triangle pick, edge differences ----------------
  logic             lower;
  logic [MAG_W-1:0] dxd, dzd;
  logic             vldD_r;
  side_t            sdD_r, sdD_nxt;
  logic [MAG_W-1:0] magx_r, magz_r;
  logic [CSW-1:0]   ulD_r, wlD_r;

  // lower-left triangle wins ties on the diagonal
  assign lower = (pzu_r <= pxw_r);
  assign dxd   = lower ? {h11[HGT_W-1], h11} - {h10[HGT_W-1], h10}
                       : {h01[HGT_W-1], h01} - {h00[HGT_W-1], h00};
  assign dzd   = lower ? {h10[HGT_W-1], h10} - {h00[HGT_W-1], h00}
                       : {h11[HGT_W-1], h11} - {h01[HGT_W-1], h01};

  always_comb begin
    sdD_nxt       = sdM_r;
    sdD_nxt.hgt   = h00;
    sdD_nxt.neg_x = dxd[MAG_W-1];
    sdD_nxt.neg_z = dzd[MAG_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vldD_r <= 1'b0;
    else        vldD_r <= vldM_r;
    sdD_r  <= sdD_nxt;
    magx_r <= dxd[MAG_W-1] ? -dxd : dxd;
    magz_r <= dzd[MAG_W-1] ? -dzd : dzd;
    ulD_r  <= ulM_r;
    wlD_r  <= wlM_r;
  end

  // ---------------- SP: magnitude times offset ----------------
  logic           vldP_r;
  side_t          sdP_r;
  logic [SNW-1:0] prx_r, prz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vldP_r <= 1'b0;
    else        vldP_r <= vldD_r;
    sdP_r <= sdD_r;
    prx_r <= SNW'(magx_r) * SNW'(ulD_r);
    prz_r <= SNW'(magz_r) * SNW'(wlD_r);
  end

  // ---------------- SN: add half divisor, rounding half away from zero ----------------
  logic           vldN_r;
  side_t          sdN_r;
  logic [SNW-1:0] numx_r, numz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vldN_r <= 1'b0;
    else        vldN_r <= vldP_r;
    sdN_r  <= sdP_r;
    numx_r <= prx_r + SNW'(dx >> 1);
    numz_r <= prz_r + SNW'(dz >> 1);
  end

  // ---------------- interpolation divide ----------------
  logic [MAG_W-1:0] qx, qz;
  logic [CSW-1:0]   rx_unused, rz_unused;

  hfq_div #(.DENW(CSW), .QW(MAG_W)) u_div_x (
    .clk(clk), .num(numx_r), .den(dx), .quo(qx), .rem(rx_unused)
  );
  hfq_div #(.DENW(CSW), .QW(MAG_W)) u_div_z (
    .clk(clk), .num(numz_r), .den(dz), .quo(qz), .rem(rz_unused)
  );

  logic [MAG_W-1:0] ivld_r;
  side_t            isd_r [MAG_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= '0;
    end else begin
      ivld_r[0] <= vldN_r;
      for (int k = 1; k < MAG_W; k++) ivld_r[k] <= ivld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    isd_r[0] <= sdN_r;
    for (int k = 1; k < MAG_W; k++) isd_r[k] <= isd_r[k-1];
  end

  // ---------------- SQ: signed sum, saturation, result register ----------------
  localparam int SW = MAG_W + 3;

  side_t           sdq;
  logic [SW-1:0]   tx, tz, hsum;
  logic [HGT_W-1:0] hsat;
  logic            out_valid_r;
  out_item_t       out_data_r;

  assign sdq  = isd_r[MAG_W-1];
  assign tx   = sdq.neg_x ? -SW'(qx) : SW'(qx);
  assign tz   = sdq.neg_z ? -SW'(qz) : SW'(qz);
  assign hsum = {{(SW-HGT_W){sdq.hgt[HGT_W-1]}}, sdq.hgt} + tx + tz;

  always_comb begin
    if (!hsum[SW-1] && (hsum[SW-2:HGT_W-1] != '0)) begin
      hsat = HGT_MAX;
    end else if (hsum[SW-1] && (hsum[SW-2:HGT_W-1] != '1)) begin
      hsat = HGT_MIN;
    end else begin
      hsat = hsum[HGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= ivld_r[MAG_W-1] & sdq.qry;
    out_data_r.height_out <= sdq.ins ? hsat : sdq.py;
    out_data_r.inside_res <= sdq.ins;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/hfq_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; den must stay stable while items are in flight.
module hfq_div #(
  parameter int DENW = 31,
  parameter int QW   = 8
) (
  input  logic                 clk,
  input  logic [DENW+QW-1:0]   num,
  input  logic [DENW-1:0]      den,
  output logic [QW-1:0]        quo,
  output logic [DENW-1:0]      rem
);
  localparam int NUMW = DENW + QW;
  localparam int DIFW = NUMW + 1;

  logic [NUMW-1:0] rem_r [QW];
  logic [QW-1:0]   quo_r [QW];

  // num must be below den << QW
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BIT = QW - 1 - k;
    logic [NUMW-1:0] rem_in;
    logic [QW-1:0]   quo_in;
    logic [DIFW-1:0] diff;
    logic [NUMW-1:0] rem_nxt;
    logic [QW-1:0]   quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      diff         = {1'b0, rem_in} - (DIFW'(den) << BIT);
      quo_nxt      = quo_in;
      quo_nxt[BIT] = ~diff[NUMW];
      rem_nxt      = diff[NUMW] ? rem_in : diff[NUMW-1:0];
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      quo_r[k] <= quo_nxt;
    end
  end

  assign quo = quo_r[QW-1];
  assign rem = rem_r[QW-1][DENW-1:0];

endmodule

@@ rtl/core/hfq_store.sv @@
// Height memory: one write port, two registered read ports.
// Uses hfq_pkg for the height width.
module hfq_store #(
  parameter int DEPTH = 4225,
  parameter int AW    = 13
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [hfq_pkg::HGT_W-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr_a,
  input  logic [AW-1:0]           rd_addr_b,
  output logic [hfq_pkg::HGT_W-1:0] rd_data_a,
  output logic [hfq_pkg::HGT_W-1:0] rd_data_b
);
  import hfq_pkg::*;

  logic [HGT_W-1:0] mem_r [DEPTH];
  logic [HGT_W-1:0] rd_a_r;
  logic [HGT_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

@@ rtl/core/hfq_chk.sv @@
// Port-level checker for heightfield_height_query, with its bind.
// Depends on hfq_pkg and the top level's ports.
module hfq_chk #(
  parameter int LAT = 48
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input hfq_pkg::in_item_t  in_data,
  input logic               out_valid,
  input hfq_pkg::out_item_t out_data
);
  import hfq_pkg::*;

  // every query transfer yields exactly one result at fixed latency
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.cmd == CMD_QUERY |-> ##LAT out_valid)
    else $error("query transfer produced no result");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.cmd == CMD_LOAD |-> ##LAT !out_valid)
    else $error("load transfer produced a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_data.cmd == CMD_QUERY, LAT))
    else $error("result without a matching query");

  // outside the grid the query y comes back unchanged
  a_outside_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_res |-> out_data.height_out == $past(in_data.pos_y, LAT))
    else $error("outside result differs from query y");

endmodule

bind heightfield_height_query hfq_chk #(.LAT(LATENCY)) u_hfq_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
  .out_valid(out_valid), .out_data(out_data)
);

@@ tb/sv/hfq_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for heightfield_height_query: watches the input, config and result ports,
// keeps its own height grid and cell sizes, and predicts each query result.
// Depends on hfq_pkg.
module hfq_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  hfq_pkg::in_item_t          in_data,
  input  logic                       out_valid,
  input  hfq_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [hfq_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [hfq_pkg::CSW-1:0]    cfg_wdata,
  output int                         fails,
  output int                         pending
);
  import hfq_pkg::*;

  localparam int GX = 64;
  localparam int GZ = 64;

  logic signed [HGT_W-1:0] grid_h [0:(GX+1)*(GZ+1)-1];
  logic [CSW-1:0] size_x, size_z;
  out_item_t heights_due[$];

  // term * num / den, rounded to nearest with ties away from zero
  function automatic longint lerp_term(longint diff, longint num, longint den);
    bit [63:0] mag, q;
    mag = (diff < 0) ? -diff : diff;
    q = (mag * num + den / 2) / den;
    return (diff < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_item_t terrain_height(in_item_t it);
    out_item_t res;
    longint dx, dz, u, w, c, r, ul, wl, h, h00, h11, h10, h01;
    dx = (size_x == 0) ? 1 : size_x;
    dz = (size_z == 0) ? 1 : size_z;
    u = longint'(it.pos_x) + dx * (GX / 2);
    w = dz * (GZ / 2) - longint'(it.pos_z);
    if (u < 0 || w < 0 || u > dx * GX || w > dz * GZ) begin
      res.height_out = it.pos_y;
      res.inside_res = 1'b0;
      return res;
    end
    c = (u == 0) ? 0 : (u - 1) / dx;
    r = (w == 0) ? 0 : (w - 1) / dz;
    ul = u - c * dx;
    wl = w - r * dz;
    h00 = grid_h[r * (GX + 1) + c];
    h11 = grid_h[(r + 1) * (GX + 1) + c + 1];
    if (dz * ul <= dx * wl) begin
      h10 = grid_h[(r + 1) * (GX + 1) + c];
      h = h00 + lerp_term(h10 - h00, wl, dz) + lerp_term(h11 - h10, ul, dx);
    end else begin
      h01 = grid_h[r * (GX + 1) + c + 1];
      h = h00 + lerp_term(h01 - h00, ul, dx) + lerp_term(h11 - h01, wl, dz);
    end
    if (h > 64'sh7fff_ffff) h = 64'sh7fff_ffff;
    if (h < -64'sh8000_0000) h = -64'sh8000_0000;
    res.height_out = h[31:0];
    res.inside_res = 1'b1;
    return res;
  endfunction

  assign pending = heights_due.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      size_x <= CELL_RESET;
      size_z <= CELL_RESET;
      fails = 0;
      heights_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_CELL_X) size_x <= cfg_wdata;
        else if (cfg_idx == CFG_CELL_Z) size_z <= cfg_wdata;
      end
      // result check first: a result this edge never belongs to a transfer this edge
      if (out_valid) begin
        if (heights_due.size() == 0) begin
          $display("%0t unexpected result: got %h/%b", $time,
                   out_data.height_out, out_data.inside_res);
          fails = fails + 1;
        end else begin
          want = heights_due.pop_front();
          if (want.height_out !== out_data.height_out) begin
            $display("%0t height_out: expected %h got %h", $time,
                     want.height_out, out_data.height_out);
            fails = fails + 1;
          end
          if (want.inside_res !== out_data.inside_res) begin
            $display("%0t inside_res: expected %b got %b", $time,
                     want.inside_res, out_data.inside_res);
            fails = fails + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_data.cmd == CMD_QUERY)
          heights_due.push_back(terrain_height(in_data));
        else if (in_data.load_row <= GZ && in_data.load_col <= GX)
          grid_h[in_data.load_row * (GX + 1) + in_data.load_col] = in_data.load_height;
      end
    end
  end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Top of the heightfield_height_query testbench: clock, reset, stimulus and verdict.
// Depends on hfq_pkg, hfq_checker and the block itself.
module tb;
  import hfq_pkg::*;

  localparam int GX = 64;
  localparam int GZ = 64;
  localparam int DRAIN = 60;
  localparam int CYCLE_LIMIT = 300000;
  localparam int IN_W = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_idx = '0;
  logic [CSW-1:0] cfg_wdata = '0;
  int fails, pending;
  int cycles = 0;
  bit no_gaps = 0;
  longint step_x = 65536, step_z = 65536;   // effective cell sizes for aiming

  heightfield_height_query DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  hfq_checker scoreboard (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // one transfer; random idle cycles ahead of it unless in the no-gap stretch
  task automatic send(in_item_t it);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // block idle: no query outstanding, then let loads in flight drain
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // only call when settled
  task automatic set_cells(logic [CSW-1:0] sx, logic [CSW-1:0] sz);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_CELL_X;
    cfg_wdata <= sx;
    @(posedge clk);
    cfg_idx <= CFG_CELL_Z;
    cfg_wdata <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_x = (sx == 0) ? 1 : sx;
    step_z = (sz == 0) ? 1 : sz;
  endtask

  function automatic logic [31:0] rand_height();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // loaded vertex bands per axis: both ends and the middle
  function automatic bit band_vertex(int v, int cells);
    return (v <= 4) || (v >= cells / 2 - 2 && v <= cells / 2 + 2) || (v >= cells - 4);
  endfunction

  // cell index along one axis, -1 when the offset lies off the grid
  function automatic int axis_cell(longint off, longint step, int cells);
    if (off < 0 || off > step * cells) return -1;
    return (off == 0) ? 0 : int'((off - 1) / step);
  endfunction

  function automatic in_item_t load_item(int r, int c, logic [31:0] h);
    in_item_t it;
    it = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom()});
    it.cmd = CMD_LOAD;
    it.load_row = IDX_W'(r);
    it.load_col = IDX_W'(c);
    it.load_height = h;
    return it;
  endfunction

  // offset inside one loaded band, on a band grid line, or a touch past either end
  function automatic longint aim(longint step, int cells);
    longint off;
    int b;
    case ($urandom_range(0, 2))
      0: b = 0;
      1: b = cells / 2 - 2;
      default: b = cells - 4;
    endcase
    case ($urandom_range(0, 9))
      0: off = -1;
      1: off = step * cells + 1;
      2: off = step * $urandom_range((b == 0) ? 0 : b + 1, b + 4);   // on a grid line
      default: off = step * (b + $urandom_range(0, 3)) + $urandom_range(1, 32'(step));
    endcase
    return off;
  endfunction

  function automatic in_item_t query_item();
    in_item_t it;
    longint px, pz;
    int cx, cz;
    it = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom()});
    it.cmd = CMD_QUERY;
    if ($urandom_range(0, 9) < 8) begin
      px = aim(step_x, GX) - step_x * (GX / 2);
      pz = step_z * (GZ / 2) - aim(step_z, GZ);
      if (px >= -64'sh8000_0000 && px <= 64'sh7fff_ffff) it.pos_x = px[31:0];
      if (pz >= -64'sh8000_0000 && pz <= 64'sh7fff_ffff) it.pos_z = pz[31:0];
    end
    // a point landing in a cell outside the loaded bands moves to the grid center
    cx = axis_cell(longint'(it.pos_x) + step_x * (GX / 2), step_x, GX);
    cz = axis_cell(step_z * (GZ / 2) - longint'(it.pos_z), step_z, GZ);
    if (cx >= 0 && cz >= 0 &&
        !(band_vertex(cx, GX) && band_vertex(cx + 1, GX) &&
          band_vertex(cz, GZ) && band_vertex(cz + 1, GZ))) begin
      it.pos_x = '0;
      it.pos_z = '0;
    end
    return it;
  endfunction

  function automatic in_item_t point_query(longint px, longint pz);
    in_item_t it;
    it = query_item();
    it.pos_x = px[31:0];
    it.pos_z = pz[31:0];
    return it;
  endfunction

  logic [CSW-1:0] sizes_x [6] = '{31'd65536, 31'd1, 31'h7fff_ffff, 31'd0, 31'd40000, 31'd0};
  logic [CSW-1:0] sizes_z [6] = '{31'd65536, 31'd1, 31'h7fff_ffff, 31'd3, 31'd100000, 31'd0};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the vertex bands; queries only reach cells inside them
    for (int r = 0; r <= GZ; r++)
      for (int c = 0; c <= GX; c++)
        if (band_vertex(r, GZ) && band_vertex(c, GX))
          send(load_item(r, c, rand_height()));

    // directed: extreme corner heights, corners, center, each side outside,
    // shared edges, and loads past the grid that must be dropped
    send(load_item(0, 0, 32'h7fff_ffff));
    send(load_item(0, 1, 32'h8000_0000));
    send(load_item(1, 0, 32'h8000_0000));
    send(load_item(1, 1, 32'h7fff_ffff));
    send(load_item(GZ, GX, 32'h8000_0000));
    send(load_item(65, 0, 32'h1234_5678));
    send(load_item(0, 127, 32'h1234_5678));
    send(load_item(127, 127, 32'h1234_5678));
    send(point_query(-32 * 65536, 32 * 65536));           // top-left corner vertex
    send(point_query(32 * 65536, -32 * 65536));           // bottom-right corner vertex
    send(point_query(-32 * 65536 + 32768, 32 * 65536 - 32768));  // diagonal of cell 0
    send(point_query(-32 * 65536 + 65536, 32 * 65536 - 32768));  // edge between cells
    send(point_query(-32 * 65536 + 40000, 32 * 65536 - 10000));  // upper-right triangle
    send(point_query(0, 0));
    send(point_query(-32 * 65536 - 1, 0));
    send(point_query(32 * 65536 + 1, 0));
    send(point_query(0, 32 * 65536 + 1));
    send(point_query(0, -32 * 65536 - 1));
    send(point_query(-64'sh8000_0000, 64'sh7fff_ffff));
    send(point_query(64'sh7fff_ffff, -64'sh8000_0000));

    // random phases over several cell sizes, zero (read as one) and extremes included
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      if (ph == 5) set_cells(CSW'($urandom_range(1, 200000)), CSW'($urandom_range(1, 200000)));
      else set_cells(sizes_x[ph], sizes_z[ph]);
      no_gaps = (ph == 2);
      for (int n = 0; n < 140; n++) begin
        if (ph == 3 && n == 90) settle();     // sender holds off until all results arrive
        if ($urandom_range(0, 4) == 0)
          send(load_item($urandom_range(0, 70), $urandom_range(0, 70), rand_height()));
        else
          send(query_item());
      end
    end

    settle();
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/hfq_pkg.sv
rtl/core/hfq_div.sv
rtl/core/hfq_store.sv
rtl/core/heightfield_height_query.sv
rtl/core/hfq_chk.sv
tb/sv/hfq_checker.sv
tb/sv/tb.sv
